/* rtl/core/tgs_pkg.sv */
// Package with shared constants, types and functions of the trilinear grid sampler.
package tgs_pkg;

   localparam int MaxDim     = 32;
   localparam int IdxBits    = $clog2(MaxDim);
   localparam int SizeBits   = 6;
   localparam int ValueBits  = 32;
   localparam int CoordBits  = 24;
   localparam int FracBits   = 16;
   localparam int WeightBits = 18;
   localparam int BankDepth  = MaxDim * MaxDim * MaxDim / 8;
   localparam int BankAddrBits = $clog2(BankDepth);
   localparam int AddrBits   = 3 * IdxBits;
   localparam int CsrAddrBits = 4;

   localparam logic [CsrAddrBits-1:0] CsrSizeX = 4'd0;
   localparam logic [CsrAddrBits-1:0] CsrSizeY = 4'd4;
   localparam logic [CsrAddrBits-1:0] CsrSizeZ = 4'd8;

   typedef enum logic {
      ACT_WRITE  = 1'b0,
      ACT_SAMPLE = 1'b1
   } action_type;

   typedef struct packed {
      logic [IdxBits-1:0]    base;
      logic [WeightBits-1:0] frac;
   } axis_type;

   // Clamp a coordinate to zero..size, cap base at size minus two, return base and fraction.
   function automatic axis_type axis_setup(input logic signed [CoordBits-1:0] coord,
                                           input logic [SizeBits-1:0] size_raw);
      logic [SizeBits-1:0] size;
      logic [CoordBits-1:0] clamped;
      logic [CoordBits-1:0] hi;
      logic [CoordBits-FracBits-1:0] whole;
      logic [CoordBits-FracBits-1:0] cap;
      logic [CoordBits-FracBits-1:0] base;
      logic [CoordBits-1:0] frac;
      axis_type result;
      size = size_raw;
      if (size < SizeBits'(2)) size = SizeBits'(2);
      if (size > SizeBits'(MaxDim)) size = SizeBits'(MaxDim);
      hi = {(CoordBits-FracBits-SizeBits)'(0), size, FracBits'(0)};
      if (coord[CoordBits-1]) clamped = '0;
      else if (coord > $signed(hi)) clamped = hi;
      else clamped = coord;
      whole = clamped[CoordBits-1:FracBits];
      cap = (CoordBits-FracBits)'(size) - (CoordBits-FracBits)'(2);
      base = (whole > cap) ? cap : whole;
      frac = clamped - {base, FracBits'(0)};
      result.base = base[IdxBits-1:0];
      result.frac = frac[WeightBits-1:0];
      return result;
   endfunction

endpackage

/* rtl/core/tgs_blend.sv */
// Blend stage: w0*a + w1*b rounded to Q16, products registered before the add.
module tgs_blend
   import tgs_pkg::*;
(
   input  logic                        clock,
   input  logic signed [39:0]          a_in_val,
   input  logic signed [39:0]          b_in_val,
   input  logic [WeightBits-1:0]       frac,
   output logic signed [39:0]          result
);

   logic signed [WeightBits+1:0] w0;
   logic signed [WeightBits+1:0] w1;
   logic signed [61:0] pa_ff;
   logic signed [61:0] pb_ff;
   logic signed [62:0] sum;
   logic signed [62:0] sum_r;

   // Weights: w1 is the fraction, w0 is one minus it (can go negative).
   assign w1 = $signed({2'b00, frac});
   assign w0 = $signed((WeightBits+2)'(1 << FracBits)) - w1;

   // Products registered before the add.
   always_ff @(posedge clock) begin
      pa_ff <= 62'(a_in_val * w0);
      pb_ff <= 62'(b_in_val * w1);
   end

   // Floor of (s + half) / 2^16 is an arithmetic shift.
   assign sum = 63'(pa_ff) + 63'(pb_ff);
   assign sum_r = sum + 63'(32768);
   assign result = 40'(sum_r >>> FracBits);

endmodule

/* rtl/core/tgs_banks.sv */
// Eight-bank grid store: one bank per corner parity, all eight corners read at once.
module tgs_banks
   import tgs_pkg::*;
(
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [IdxBits-1:0]         wr_x,
   input  logic [IdxBits-1:0]         wr_y,
   input  logic [IdxBits-1:0]         wr_z,
   input  logic signed [ValueBits-1:0] wr_data,
   input  logic [IdxBits-1:0]         rd_x,
   input  logic [IdxBits-1:0]         rd_y,
   input  logic [IdxBits-1:0]         rd_z,
   output logic signed [ValueBits-1:0] rd_data [8]
);

   logic [BankAddrBits-1:0] wr_addr;
   logic [2:0]              wr_bank;
   logic [2:0]              par_ff;
   logic signed [ValueBits-1:0] bank_q [8];

   assign wr_addr = {wr_x[IdxBits-1:1], wr_y[IdxBits-1:1], wr_z[IdxBits-1:1]};
   assign wr_bank = {wr_x[0], wr_y[0], wr_z[0]};

   // Corner c = {dx,dy,dz}; each bank serves the corner whose parity matches.
   for (genvar c = 0; c < 8; c++) begin : g_bank
      logic signed [ValueBits-1:0] mem [BankDepth];
      logic signed [ValueBits-1:0] q_ff;
      logic [IdxBits-1:0] cx, cy, cz;
      logic [IdxBits-1:0] ex, ey, ez;
      logic [2:0] corner;
      logic [BankAddrBits-1:0] rd_addr;

      // Find which corner of the cube maps to this bank.
      assign corner = 3'(c) ^ {rd_x[0], rd_y[0], rd_z[0]};
      assign ex = rd_x + IdxBits'(corner[2]);
      assign ey = rd_y + IdxBits'(corner[1]);
      assign ez = rd_z + IdxBits'(corner[0]);
      assign cx = ex;
      assign cy = ey;
      assign cz = ez;
      assign rd_addr = {cx[IdxBits-1:1], cy[IdxBits-1:1], cz[IdxBits-1:1]};

      always_ff @(posedge clock) begin
         if (wr_en && wr_bank == 3'(c)) begin
            mem[wr_addr] <= wr_data;
         end
         q_ff <= mem[rd_addr];
      end

      assign bank_q[c] = q_ff;
   end

   // Parity of the base point, kept to route each bank word back to its corner.
   always_ff @(posedge clock) begin
      par_ff <= {rd_x[0], rd_y[0], rd_z[0]};
   end

   // Corner d was read from the bank whose index is d xor the base parity.
   always_comb begin
      for (int d = 0; d < 8; d++) rd_data[d] = bank_q[3'(d) ^ par_ff];
   end

endmodule

/* rtl/core/trilinear_grid_sampler.sv */
// Top level of the trilinear grid sampler: CSRs, pipeline control and the blend stages.
//
// Usage: drive a word on the req_ ports with start high; busy is always low, so a
// word is taken every cycle. A write word (req_action = 0) stores req_entry_value
// in the grid at (req_entry_x, req_entry_y, req_entry_z) and returns nothing.
// A sample word returns one rsp_sample_value, marked by rsp_valid for one cycle,
// after it passes the axis setup register, the banked corner read, the x and y
// blends (each a multiply register, then add and round into a pipeline register),
// the z multiply and the output register that adds, rounds and saturates.
// Throughput is one word per cycle, set by the eight banks.
// A write is registered and then stored in its bank, after the corner read of the
// sample accepted just before it but before that of any later sample.
// Grid sizes sit in CSRs size_x, size_y, size_z at byte addresses 0, 4 and 8,
// reset to 32; write them only while no sample is in flight.
// Reset returns the CSRs to 32 and clears the pipeline valid bits; the grid is
// undefined until written. The receiver cannot stall; results are never held.
module trilinear_grid_sampler
   import tgs_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [IdxBits-1:0]            req_entry_x,
   input  logic [IdxBits-1:0]            req_entry_y,
   input  logic [IdxBits-1:0]            req_entry_z,
   input  logic signed [ValueBits-1:0]   req_entry_value,
   input  logic signed [CoordBits-1:0]   req_coord_x,
   input  logic signed [CoordBits-1:0]   req_coord_y,
   input  logic signed [CoordBits-1:0]   req_coord_z,
   output logic                          rsp_valid,
   output logic signed [ValueBits-1:0]   rsp_sample_value,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CsrAddrBits-1:0]        paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic [SizeBits-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic                csr_wr;

   // Valid bits for the seven stages ahead of the output register.
   logic [6:0] vld_ff;
   logic [6:0] vld_in;

   axis_type ax_ff, ay_ff, az_ff;
   axis_type ax_in, ay_in, az_in;
   logic [WeightBits-1:0] fx_ff, fy_ff [3], fz_ff [5];

   logic                         wr_en_ff;
   logic [IdxBits-1:0]           wx_ff, wy_ff, wz_ff;
   logic signed [ValueBits-1:0]  wd_ff;

   logic signed [ValueBits-1:0] corner [8];
   logic signed [39:0] rx [4];
   logic signed [39:0] sy [2];
   logic signed [39:0] rz;
   logic signed [ValueBits-1:0] sat;

   assign busy = 1'b0;
   assign pready = 1'b1;

   // CSR writes and reads.
   assign csr_wr = psel && penable && pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SizeBits'(32);
         size_y_ff <= SizeBits'(32);
         size_z_ff <= SizeBits'(32);
      end else if (csr_wr) begin
         unique case (paddr)
            CsrSizeX: size_x_ff <= pwdata[SizeBits-1:0];
            CsrSizeY: size_y_ff <= pwdata[SizeBits-1:0];
            CsrSizeZ: size_z_ff <= pwdata[SizeBits-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr)
         CsrSizeX: prdata = 32'(size_x_ff);
         CsrSizeY: prdata = 32'(size_y_ff);
         CsrSizeZ: prdata = 32'(size_z_ff);
         default:  prdata = '0;
      endcase
   end

   // Stage 1: axis setup; write word registered.
   assign ax_in = axis_setup(req_coord_x, size_x_ff);
   assign ay_in = axis_setup(req_coord_y, size_y_ff);
   assign az_in = axis_setup(req_coord_z, size_z_ff);
   assign vld_in = {vld_ff[5:0], start && req_action == ACT_SAMPLE};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         wr_en_ff <= 1'b0;
      end else begin
         vld_ff   <= vld_in;
         wr_en_ff <= start && req_action == ACT_WRITE;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      az_ff <= az_in;
      wx_ff <= req_entry_x;
      wy_ff <= req_entry_y;
      wz_ff <= req_entry_z;
      wd_ff <= req_entry_value;
      fx_ff <= ax_ff.frac;
      fy_ff[0] <= ay_ff.frac;
      fz_ff[0] <= az_ff.frac;
      for (int i = 1; i < 3; i++) fy_ff[i] <= fy_ff[i-1];
      for (int i = 1; i < 5; i++) fz_ff[i] <= fz_ff[i-1];
   end

   // Stage 2: banked corner read.
   tgs_banks u_banks (
      .clock   (clock),
      .wr_en   (wr_en_ff),
      .wr_x    (wx_ff),
      .wr_y    (wy_ff),
      .wr_z    (wz_ff),
      .wr_data (wd_ff),
      .rd_x    (ax_ff.base),
      .rd_y    (ay_ff.base),
      .rd_z    (az_ff.base),
      .rd_data (corner)
   );

   // Stages 3-4: blend along x. Corner index is {dx,dy,dz}.
   for (genvar g = 0; g < 4; g++) begin : g_bx
      tgs_blend u_bx (
         .clock    (clock),
         .a_in_val (40'(corner[g])),
         .b_in_val (40'(corner[g+4])),
         .frac     (fx_ff),
         .result   (rx[g])
      );
   end

   // Pipeline registers between the x and y blends and between the y and z blends.
   logic signed [39:0] rx_ff [4];
   logic signed [39:0] sy_ff [2];
   always_ff @(posedge clock) begin
      rx_ff <= rx;
      sy_ff <= sy;
   end

   // Stages 5-6: blend along y (rx index is {dy,dz}).
   for (genvar g = 0; g < 2; g++) begin : g_by
      tgs_blend u_by (
         .clock    (clock),
         .a_in_val (rx_ff[g]),
         .b_in_val (rx_ff[g+2]),
         .frac     (fy_ff[2]),
         .result   (sy[g])
      );
   end

   // Stages 7-8: blend along z and saturate.
   tgs_blend u_bz (
      .clock    (clock),
      .a_in_val (sy_ff[0]),
      .b_in_val (sy_ff[1]),
      .frac     (fz_ff[4]),
      .result   (rz)
   );

   always_comb begin
      if (rz > 40'sh007FFFFFFF) sat = 32'sh7FFFFFFF;
      else if (rz < -40'sh0080000000) sat = 32'sh80000000;
      else sat = rz[ValueBits-1:0];
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= vld_ff[6];
      rsp_sample_value <= sat;
   end

   // A result appears only after a sample was accepted earlier.
   a_rsp_from_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(vld_ff[0], 7)) else $error("result without sample");
   a_no_write_result: assert property (@(posedge clock) disable iff (reset)
      wr_en_ff |-> !vld_ff[0]) else $error("write and sample in one stage");
   a_busy_low: assert property (@(posedge clock) !busy) else $error("busy raised");

endmodule

/* test/trilinear_grid_sampler_tb.sv */
// Self-checking testbench of the trilinear grid sampler: directed table, then random words.
module trilinear_grid_sampler_tb;
   import tgs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      action_type  act;
      logic [4:0]  ex, ey, ez;
      logic [31:0] value;
      logic [23:0] cx, cy, cz;
      bit          has_exp;
      logic [31:0] exp_value;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_action = 1'b0;
   logic [IdxBits-1:0] req_entry_x = '0, req_entry_y = '0, req_entry_z = '0;
   logic signed [ValueBits-1:0] req_entry_value = '0;
   logic signed [CoordBits-1:0] req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic rsp_valid;
   logic signed [ValueBits-1:0] rsp_sample_value;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CsrAddrBits-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // Shadow of the grid and of the size registers.
   logic [31:0] grid_copy [0:32767];
   bit          grid_written [0:32767];
   logic [5:0]  dim_x = 6'd32, dim_y = 6'd32, dim_z = 6'd32;
   logic [31:0] pending_samples [$];
   stim_type    directed_rows [$];
   int          errors = 0;
   int          idle_pct = 0;

   trilinear_grid_sampler dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic int eff_dim(logic [5:0] s);
      if (s < 2) return 2;
      if (s > MaxDim) return MaxDim;
      return s;
   endfunction

   // Clamp one coordinate, find its base point and its Q16 fraction.
   function automatic void axis_split(logic [23:0] c, logic [5:0] s,
                                      output int base, output longint frac);
      longint v, hi;
      int n;
      n = eff_dim(s);
      v = longint'($signed(c));
      hi = longint'(n) * 65536;
      if (v < 0) v = 0;
      if (v > hi) v = hi;
      base = int'(v >>> 16);
      if (base > n - 2) base = n - 2;
      frac = v - longint'(base) * 65536;
   endfunction

   function automatic int grid_index(int x, int y, int z);
      return (x * MaxDim + y) * MaxDim + z;
   endfunction

   function automatic longint lerp_q16(longint a, longint b, longint f);
      return ((65536 - f) * a + f * b + 32768) >>> 16;
   endfunction

   function automatic longint corner(int x, int y, int z);
      return longint'($signed(grid_copy[grid_index(x, y, z)]));
   endfunction

   // Expected sample value for a coordinate under the current sizes.
   function automatic logic [31:0] interpolate(logic [23:0] cx, logic [23:0] cy,
                                               logic [23:0] cz);
      int i, j, k;
      longint fx, fy, fz, r00, r10, r01, r11, s0, s1, r;
      axis_split(cx, dim_x, i, fx);
      axis_split(cy, dim_y, j, fy);
      axis_split(cz, dim_z, k, fz);
      r00 = lerp_q16(corner(i, j, k), corner(i + 1, j, k), fx);
      r10 = lerp_q16(corner(i, j + 1, k), corner(i + 1, j + 1, k), fx);
      r01 = lerp_q16(corner(i, j, k + 1), corner(i + 1, j, k + 1), fx);
      r11 = lerp_q16(corner(i, j + 1, k + 1), corner(i + 1, j + 1, k + 1), fx);
      s0 = lerp_q16(r00, r10, fy);
      s1 = lerp_q16(r01, r11, fy);
      r = lerp_q16(s0, s1, fz);
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      return r[31:0];
   endfunction

   // Present one word, wait for acceptance, then update the shadow state.
   task automatic send_word(stim_type w);
      bit taken;
      taken = 1'b0;
      start <= 1'b1;
      req_action <= w.act;
      req_entry_x <= w.ex;
      req_entry_y <= w.ey;
      req_entry_z <= w.ez;
      req_entry_value <= w.value;
      req_coord_x <= w.cx;
      req_coord_y <= w.cy;
      req_coord_z <= w.cz;
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end
      if (w.act == ACT_WRITE) begin
         grid_copy[grid_index(w.ex, w.ey, w.ez)] = w.value;
         grid_written[grid_index(w.ex, w.ey, w.ez)] = 1'b1;
      end else if (w.has_exp) begin
         pending_samples.push_back(w.exp_value);
      end else begin
         pending_samples.push_back(interpolate(w.cx, w.cy, w.cz));
      end
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic csr_write(logic [CsrAddrBits-1:0] addr, logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Stop sending and let the pipeline drain completely.
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic stim_type make_word(action_type a, int x, int y, int z,
                                          logic [31:0] v, logic [23:0] cx,
                                          logic [23:0] cy, logic [23:0] cz,
                                          bit has_exp, logic [31:0] e);
      stim_type w;
      w.act = a;
      w.ex = 5'(x);
      w.ey = 5'(y);
      w.ez = 5'(z);
      w.value = v;
      w.cx = cx;
      w.cy = cy;
      w.cz = cz;
      w.has_exp = has_exp;
      w.exp_value = e;
      return w;
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1: return $urandom;
         default: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      endcase
   endfunction

   function automatic logic [23:0] rand_coord(logic [5:0] s);
      int n;
      n = eff_dim(s);
      case ($urandom_range(0, 3))
         0: return 24'($urandom);
         1: return 24'($urandom_range((n - 2) * 65536, (n + 1) * 65536));
         default: return 24'($signed($urandom_range(0, 4 * 65536)) - 65536);
      endcase
   endfunction

   // Random word: a write, or a sample whose corners are all written. A sample
   // that would touch an unwritten corner becomes a write to that corner.
   function automatic stim_type random_word();
      stim_type w;
      int i, j, k;
      longint f;
      w = make_word(ACT_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 31), rand_value(), 24'($urandom),
                    24'($urandom), 24'($urandom), 1'b0, '0);
      if ($urandom_range(0, 2) == 0) return w;
      w.act = ACT_SAMPLE;
      w.cx = rand_coord(dim_x);
      w.cy = rand_coord(dim_y);
      w.cz = rand_coord(dim_z);
      axis_split(w.cx, dim_x, i, f);
      axis_split(w.cy, dim_y, j, f);
      axis_split(w.cz, dim_z, k, f);
      for (int d = 0; d < 8; d++) begin
         if (!grid_written[grid_index(i + d[2], j + d[1], k + d[0])]) begin
            w.act = ACT_WRITE;
            w.ex = 5'(i + d[2]);
            w.ey = 5'(j + d[1]);
            w.ez = 5'(k + d[0]);
         end
      end
      return w;
   endfunction

   // Result checker: outputs are stable at the falling edge.
   always @(negedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_samples.size() == 0) begin
            $display("%0t: unexpected word, actual %h", $time, rsp_sample_value);
            errors++;
         end else if (rsp_sample_value !== pending_samples[0]) begin
            $display("%0t: sample_value expected %h actual %h", $time,
                     pending_samples[0], rsp_sample_value);
            errors++;
            void'(pending_samples.pop_front());
         end else begin
            void'(pending_samples.pop_front());
         end
      end
   end

   initial begin
      logic [5:0] phase_dims [4][3];
      int total;
      phase_dims = '{'{6'd2, 6'd2, 6'd2}, '{6'd0, 6'd63, 6'd5},
                     '{6'd32, 6'd32, 6'd32}, '{6'd3, 6'd1, 6'd2}};
      total = 4 * 110;
      for (int n = 0; n < 32768; n++) grid_written[n] = 1'b0;

      // Directed table: corners of the first cell, x = 0 at max, x = 1 at min.
      for (int d = 0; d < 8; d++)
         directed_rows.push_back(make_word(ACT_WRITE, d[2], d[1], d[0],
                                           d[2] ? 32'h8000_0000 : 32'h7FFF_FFFF,
                                           '0, '0, '0, 1'b0, '0));
      // The far face of the next cell along x, read with weight zero below.
      for (int d = 0; d < 4; d++)
         directed_rows.push_back(make_word(ACT_WRITE, 2, d[1], d[0], '0,
                                           '0, '0, '0, 1'b0, '0));
      directed_rows.push_back(make_word(ACT_SAMPLE, 31, 31, 31, '1, 24'h0, 24'h0,
                                        24'h0, 1'b1, 32'h7FFF_FFFF));
      directed_rows.push_back(make_word(ACT_SAMPLE, 0, 0, 0, '0, 24'h80_0000,
                                        24'h80_0000, 24'h80_0000, 1'b1, 32'h7FFF_FFFF));
      directed_rows.push_back(make_word(ACT_SAMPLE, 0, 0, 0, '0, 24'h01_0000, 24'h0,
                                        24'h0, 1'b1, 32'h8000_0000));
      directed_rows.push_back(make_word(ACT_SAMPLE, 0, 0, 0, '0, 24'h00_8000,
                                        24'h00_4000, 24'h00_C000, 1'b0, '0));
      // Top cell, then a sample clamped from the far end of every axis.
      for (int d = 0; d < 8; d++)
         directed_rows.push_back(make_word(ACT_WRITE, 30 + d[2], 30 + d[1], 30 + d[0],
                                           rand_value(), '0, '0, '0, 1'b0, '0));
      directed_rows.push_back(make_word(ACT_SAMPLE, 0, 0, 0, '0, 24'h7F_FFFF,
                                        24'h7F_FFFF, 24'h7F_FFFF, 1'b0, '0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_pct = 15;
      foreach (directed_rows[r]) send_word(directed_rows[r]);
      drain();

      // Random phases, each under its own grid sizes.
      for (int p = 0; p < 4; p++) begin
         dim_x = phase_dims[p][0];
         dim_y = phase_dims[p][1];
         dim_z = phase_dims[p][2];
         csr_write(CsrSizeX, {26'd0, dim_x});
         csr_write(CsrSizeY, {26'd0, dim_y});
         csr_write(CsrSizeZ, {26'd0, dim_z});
         for (int n = 0; n < 110; n++) begin
            int seq;
            seq = p * 110 + n;
            idle_pct = (seq < total / 3) ? 15 : (seq < 2 * total / 3) ? 61 : 0;
            if (p == 1 && n == 50) drain();
            send_word(random_word());
         end
         drain();
      end

      if (errors == 0 && pending_samples.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
